// ===== src/acs_pkg.sv =====
`timescale 1ns / 1ps
package acs_pkg;

  // Converter code width of every channel
  localparam int SAMPLE_BITS = 16;

  localparam int THR_W    = 15;
  localparam int OHMS_W   = 24;
  localparam int SCALE_W  = 16;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 3;
  localparam int VALUE_W  = 32;

  localparam int NUM_LANES = 4;

  // Magnitude of a code needs the full code width (full-scale negative)
  localparam int MAG_W  = SAMPLE_BITS;
  localparam int CMP_W  = (MAG_W > THR_W) ? MAG_W : THR_W;
  localparam int PROD_W = MAG_W + SCALE_W;
  // ohms * 10 stays below 2^(OHMS_W + 4)
  localparam int DIV_W  = OHMS_W + 4;
  // Quotient widened so both saturation limits are representable
  localparam int QX_W   = (PROD_W > VALUE_W + 1) ? PROD_W : VALUE_W + 1;

  typedef enum logic [1:0] {
    CH_LOW_X1   = 2'd0,
    CH_LOW_X10  = 2'd1,
    CH_HIGH_X1  = 2'd2,
    CH_HIGH_X10 = 2'd3
  } acs_chan_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_RANGE_THR  = 3'd0,
    REG_LOW_GAIN_THR   = 3'd1,
    REG_HIGH_RANGE_THR = 3'd2,
    REG_CLAMP_LEVEL    = 3'd3,
    REG_LOW_OHMS       = 3'd4,
    REG_HIGH_OHMS      = 3'd5,
    REG_OUTPUT_SCALE   = 3'd6
  } acs_reg_e;

  typedef struct packed {
    logic [THR_W-1:0] lo;
    logic [THR_W-1:0] hi;
  } acs_thr_t;

  typedef struct packed {
    logic             hit;
    logic             neg;
    logic [MAG_W-1:0] mag;
  } acs_lane_t;

  typedef struct packed {
    logic [DIV_W-1:0]  rem;
    logic [PROD_W-1:0] work;
    logic [DIV_W-1:0]  divisor;
    logic              neg;
    acs_chan_e         chan;
  } acs_div_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] current_value;
    acs_chan_e                 chan;
    logic                      sat;
  } acs_res_t;

endpackage

// ===== src/acs_intf.sv =====
`timescale 1ns / 1ps
interface acs_in_if;
  import acs_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] low_x1_sample;
  logic signed [SAMPLE_BITS-1:0] low_x10_sample;
  logic signed [SAMPLE_BITS-1:0] high_x1_sample;
  logic signed [SAMPLE_BITS-1:0] high_x10_sample;

  modport source (
    output valid, low_x1_sample, low_x10_sample, high_x1_sample, high_x10_sample,
    input  ready
  );
  modport sink (
    input  valid, low_x1_sample, low_x10_sample, high_x1_sample, high_x10_sample,
    output ready
  );
endinterface

interface acs_out_if;
  import acs_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] current_value;
  logic [1:0]                source_channel;
  logic                      saturated;

  modport source (
    output valid, current_value, source_channel, saturated,
    input  ready
  );
  modport sink (
    input  valid, current_value, source_channel, saturated,
    output ready
  );
endinterface

// ===== src/acs_lane.sv =====
`timescale 1ns / 1ps
module acs_lane (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  acs_pkg::acs_chan_e                     chan_i,
  input  acs_pkg::acs_thr_t                      thr_i,
  input  logic signed [acs_pkg::SAMPLE_BITS-1:0] sample_i,
  output acs_pkg::acs_lane_t                     lane_o
);
  import acs_pkg::*;

  logic             neg;
  logic [MAG_W-1:0] mag;
  logic [CMP_W-1:0] mag_x;
  logic [CMP_W-1:0] lo_x;
  logic [CMP_W-1:0] hi_x;
  logic             hit;
  acs_lane_t        lane_q;

  assign neg   = sample_i[SAMPLE_BITS-1];
  assign mag   = neg ? MAG_W'(~sample_i + 1'b1) : MAG_W'(sample_i);
  assign mag_x = CMP_W'(mag);
  assign lo_x  = CMP_W'(thr_i.lo);
  assign hi_x  = CMP_W'(thr_i.hi);

  // Range rule of this lane's channel
  always_comb begin
    case (chan_i)
      CH_LOW_X1:   hit = (mag_x >= lo_x);
      CH_LOW_X10:  hit = (mag_x > lo_x);
      CH_HIGH_X1:  hit = (mag_x > lo_x) && (mag_x < hi_x);
      CH_HIGH_X10: hit = 1'b1;
      default:     hit = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q.hit <= hit;
      lane_q.neg <= neg;
      lane_q.mag <= mag;
    end
  end

  assign lane_o = lane_q;

endmodule

// ===== src/acs_merge.sv =====
`timescale 1ns / 1ps
module acs_merge (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          en_i,
  input  logic                                          valid_i,
  input  acs_pkg::acs_lane_t [acs_pkg::NUM_LANES-1:0]   lanes_i,
  input  logic [acs_pkg::OHMS_W-1:0]                    low_ohms_i,
  input  logic [acs_pkg::OHMS_W-1:0]                    high_ohms_i,
  input  logic [acs_pkg::SCALE_W-1:0]                   scale_i,
  output logic                                          valid_o,
  output acs_pkg::acs_div_t                             data_o
);
  import acs_pkg::*;

  acs_chan_e         chan;
  acs_lane_t         sel;
  logic [OHMS_W-1:0] ohms;
  logic [DIV_W-1:0]  ohms_x;
  logic [DIV_W-1:0]  divisor;
  logic              valid_q;
  acs_div_t          data_q;

  // Priority: low x1, low x10, high x1, then high x10 as fallback
  always_comb begin
    if (lanes_i[0].hit) begin
      chan = CH_LOW_X1;
    end else if (lanes_i[1].hit) begin
      chan = CH_LOW_X10;
    end else if (lanes_i[2].hit) begin
      chan = CH_HIGH_X1;
    end else begin
      chan = CH_HIGH_X10;
    end
  end

  assign sel  = lanes_i[chan];
  assign ohms = (chan == CH_LOW_X1 || chan == CH_LOW_X10) ? low_ohms_i : high_ohms_i;
  // Zero ohms reads as one ohm
  assign ohms_x = (ohms == '0) ? DIV_W'(1) : DIV_W'(ohms);
  // Times ten as 8x + 2x
  assign divisor = (chan == CH_LOW_X10 || chan == CH_HIGH_X10)
                 ? ((ohms_x << 3) + (ohms_x << 1)) : ohms_x;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q.rem     <= '0;
      data_q.work    <= PROD_W'(sel.mag) * PROD_W'(scale_i);
      data_q.divisor <= divisor;
      data_q.neg     <= sel.neg;
      data_q.chan    <= chan;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== src/acs_div_step.sv =====
`timescale 1ns / 1ps
module acs_div_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  acs_pkg::acs_div_t data_i,
  output logic              valid_o,
  output acs_pkg::acs_div_t data_o
);
  import acs_pkg::*;

  logic [DIV_W:0] trial;
  logic [DIV_W:0] diff;
  logic           ge;
  acs_div_t       nxt;
  logic           valid_q;
  acs_div_t       data_q;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {data_i.rem, data_i.work[PROD_W-1]};
  assign diff  = trial - {1'b0, data_i.divisor};
  assign ge    = (trial >= {1'b0, data_i.divisor});

  always_comb begin
    nxt      = data_i;
    nxt.rem  = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    nxt.work = {data_i.work[PROD_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= nxt;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== src/autorange_channel_stitcher.sv =====
`timescale 1ns / 1ps
// Autorange channel stitcher. Each request carries one scan of four signed
// converter codes (low-sense x1, low-sense x10, high-sense x1, high-sense
// x10). The block picks the best-ranged channel and returns
// code * output_scale / (ohms * gain), gain 10 on the x10 channels, truncated
// toward zero and clamped to 32 bits with a saturated flag. Throughput is one
// scan per clock while the pipeline is not held. A scan is registered in the
// four magnitude/range lanes, then in channel merge, scale multiply and divisor
// build, then in one restoring-divider stage per quotient bit (SAMPLE_BITS + 16
// stages), and last in the saturating output register. A two-entry output
// buffer keeps in_i.ready a register output; the pipeline holds only while
// that buffer is full. Configuration registers must be written while no
// request is in flight. No memory, no clearing pass after reset.
module autorange_channel_stitcher (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [acs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [acs_pkg::CFG_W-1:0]       cfg_wdata_i,
  acs_in_if.sink                          in_i,
  acs_out_if.source                       out_o
);
  import acs_pkg::*;

  // Configuration registers
  logic [THR_W-1:0]   low_range_thr_q;
  logic [THR_W-1:0]   low_gain_thr_q;
  logic [THR_W-1:0]   high_range_thr_q;
  logic [THR_W-1:0]   clamp_level_q;
  logic [OHMS_W-1:0]  low_ohms_q;
  logic [OHMS_W-1:0]  high_ohms_q;
  logic [SCALE_W-1:0] scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_range_thr_q  <= '0;
      low_gain_thr_q   <= '0;
      high_range_thr_q <= '0;
      clamp_level_q    <= {THR_W{1'b1}};
      low_ohms_q       <= OHMS_W'(1);
      high_ohms_q      <= OHMS_W'(1);
      scale_q          <= SCALE_W'(1);
    end else if (cfg_we_i) begin
      case (acs_reg_e'(cfg_idx_i))
        REG_LOW_RANGE_THR:  low_range_thr_q  <= cfg_wdata_i[THR_W-1:0];
        REG_LOW_GAIN_THR:   low_gain_thr_q   <= cfg_wdata_i[THR_W-1:0];
        REG_HIGH_RANGE_THR: high_range_thr_q <= cfg_wdata_i[THR_W-1:0];
        REG_CLAMP_LEVEL:    clamp_level_q    <= cfg_wdata_i[THR_W-1:0];
        REG_LOW_OHMS:       low_ohms_q       <= cfg_wdata_i[OHMS_W-1:0];
        REG_HIGH_OHMS:      high_ohms_q      <= cfg_wdata_i[OHMS_W-1:0];
        REG_OUTPUT_SCALE:   scale_q          <= cfg_wdata_i[SCALE_W-1:0];
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // Pipeline advance: everything moves while the output skid entry is free
  logic      en;
  logic      skid_v_q;
  logic      out_v_q;
  acs_res_t  out_q;
  acs_res_t  skid_q;

  assign en       = !skid_v_q;
  assign in_i.ready = en;

  // Lane stage: one lane per channel, each with its own range rule
  logic signed [SAMPLE_BITS-1:0]   samples [NUM_LANES];
  acs_thr_t                        thr     [NUM_LANES];
  acs_lane_t [NUM_LANES-1:0]       lanes;
  logic                            lane_v_q;

  assign samples[0] = in_i.low_x1_sample;
  assign samples[1] = in_i.low_x10_sample;
  assign samples[2] = in_i.high_x1_sample;
  assign samples[3] = in_i.high_x10_sample;

  assign thr[0] = '{lo: low_range_thr_q,  hi: clamp_level_q};
  assign thr[1] = '{lo: low_gain_thr_q,   hi: clamp_level_q};
  assign thr[2] = '{lo: high_range_thr_q, hi: clamp_level_q};
  assign thr[3] = '{lo: high_range_thr_q, hi: clamp_level_q};

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    acs_lane u_lane (
      .clk_i    (clk_i),
      .en_i     (en),
      .chan_i   (acs_chan_e'(g)),
      .thr_i    (thr[g]),
      .sample_i (samples[g]),
      .lane_o   (lanes[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_v_q <= 1'b0;
    end else if (en) begin
      lane_v_q <= in_i.valid;
    end
  end

  // Merge stage: choose the channel, form product and divisor
  logic     div_v [PROD_W+1];
  acs_div_t div_d [PROD_W+1];

  acs_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (lane_v_q),
    .lanes_i     (lanes),
    .low_ohms_i  (low_ohms_q),
    .high_ohms_i (high_ohms_q),
    .scale_i     (scale_q),
    .valid_o     (div_v[0]),
    .data_o      (div_d[0])
  );

  // Divider: one quotient bit per stage, MSB first
  for (genvar s = 0; s < PROD_W; s++) begin : g_div
    acs_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (div_v[s]),
      .data_i  (div_d[s]),
      .valid_o (div_v[s+1]),
      .data_o  (div_d[s+1])
    );
  end

  // Saturate the quotient and restore the sign
  logic [QX_W-1:0] qx;
  acs_res_t        res;

  assign qx = QX_W'(div_d[PROD_W].work);

  always_comb begin
    res.chan = div_d[PROD_W].chan;
    res.sat  = 1'b0;
    if (div_d[PROD_W].neg) begin
      if (qx > QX_W'(32'h8000_0000)) begin
        res.current_value = 32'sh8000_0000;
        res.sat           = 1'b1;
      end else begin
        res.current_value = VALUE_W'(~qx[VALUE_W-1:0] + 1'b1);
      end
    end else begin
      if (qx > QX_W'(32'h7FFF_FFFF)) begin
        res.current_value = 32'sh7FFF_FFFF;
        res.sat           = 1'b1;
      end else begin
        res.current_value = qx[VALUE_W-1:0];
      end
    end
  end

  // Output register plus skid entry
  logic arrive;
  logic out_take;
  logic out_free;

  assign arrive   = en && div_v[PROD_W];
  assign out_take = out_v_q && out_o.ready;
  assign out_free = !out_v_q || out_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (skid_v_q) begin
        // Pipeline is held; drain the skid entry into the output
        if (out_take) begin
          skid_v_q <= 1'b0;
        end
      end else if (arrive) begin
        if (out_free) begin
          out_v_q <= 1'b1;
        end else begin
          skid_v_q <= 1'b1;
        end
      end else if (out_take) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (arrive) begin
      if (out_free) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_o.valid          = out_v_q;
  assign out_o.current_value  = out_q.current_value;
  assign out_o.source_channel = out_q.chan;
  assign out_o.saturated      = out_q.sat;

endmodule

// ===== src/acs_checker.sv =====
`timescale 1ns / 1ps
module acs_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [acs_pkg::VALUE_W-1:0] current_value,
  input logic [1:0]                        source_channel,
  input logic                              saturated
);
  import acs_pkg::*;

  // A held result stays put until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(current_value)
      && $stable(source_channel) && $stable(saturated))
    else $error("output request changed while stalled");

  // Saturation only ever shows one of the two limits
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && saturated |->
      (current_value == 32'sh7FFF_FFFF) || (current_value == 32'sh8000_0000))
    else $error("saturated flag without a limit value");

  // With no result pending, the skid entry is empty and input is open
  a_ready_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // Input blocks only after a stall on the output side
  a_block_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("input blocked without output stall");

endmodule

bind autorange_channel_stitcher acs_checker u_acs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready       (in_i.ready),
  .out_valid      (out_o.valid),
  .out_ready      (out_o.ready),
  .current_value  (out_o.current_value),
  .source_channel (out_o.source_channel),
  .saturated      (out_o.saturated)
);

// ===== sim/autorange_channel_stitcher_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the autorange channel stitcher.
module autorange_channel_stitcher_tb;
  import acs_pkg::*;

  localparam int PIPE_LATENCY = SAMPLE_BITS + 19;
  localparam int STUCK_LIMIT  = 2000;
  localparam int IDLE_PCT     = 37;
  localparam int X10_GAIN     = 10;
  // Index past the last register; writes to it must leave every register alone
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] lx1;
    logic signed [SAMPLE_BITS-1:0] lx10;
    logic signed [SAMPLE_BITS-1:0] hx1;
    logic signed [SAMPLE_BITS-1:0] hx10;
  } scan_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  acs_in_if  in_bus ();
  acs_out_if out_bus ();

  autorange_channel_stitcher uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_bus),
    .out_o       (out_bus)
  );

  // Shadow copy of the register file, updated as each write is issued
  logic [THR_W-1:0]   thr_low_range;
  logic [THR_W-1:0]   thr_low_gain;
  logic [THR_W-1:0]   thr_high_range;
  logic [THR_W-1:0]   clamp_lvl;
  logic [OHMS_W-1:0]  ohms_low;
  logic [OHMS_W-1:0]  ohms_high;
  logic [SCALE_W-1:0] out_scale;

  scan_t    scan_queue[$];     // scans waiting to be offered
  acs_res_t reading_queue[$];  // predicted readings, oldest first
  scan_t    cur_scan;
  acs_res_t want;
  int       scans_in_flight = 0;
  int       errors = 0;
  int       stuck_cycles = 0;
  logic     calm = 1'b0;       // when set, neither side idles

  initial begin
    forever #5 clk = ~clk;
  end

  // Magnitude of a two's complement code; full-scale negative gives 2^15
  function automatic logic [SAMPLE_BITS:0] code_mag(logic signed [SAMPLE_BITS-1:0] c);
    logic [SAMPLE_BITS:0] w;
    w = {c[SAMPLE_BITS-1], c};
    if (c[SAMPLE_BITS-1]) w = ~w + 1'b1;
    return w;
  endfunction

  // Compute the reading the block must return for one scan
  function automatic acs_res_t predict_reading(scan_t s);
    logic [SAMPLE_BITS:0]          m0, m1, m2, mag;
    logic signed [SAMPLE_BITS-1:0] code;
    logic [63:0]                   num, den, quot;
    acs_res_t                      r;
    m0 = code_mag(s.lx1);
    m1 = code_mag(s.lx10);
    m2 = code_mag(s.hx1);
    // Prefer the coarse low channel, then step down to the finer ones
    if (m0 >= thr_low_range) r.chan = CH_LOW_X1;
    else if (m1 > thr_low_gain) r.chan = CH_LOW_X10;
    else if (m2 > thr_high_range && m2 < clamp_lvl) r.chan = CH_HIGH_X1;
    else r.chan = CH_HIGH_X10;
    case (r.chan)
      CH_LOW_X1:  code = s.lx1;
      CH_LOW_X10: code = s.lx10;
      CH_HIGH_X1: code = s.hx1;
      default:    code = s.hx10;
    endcase
    mag = code_mag(code);
    den = (r.chan == CH_LOW_X1 || r.chan == CH_LOW_X10) ? 64'(ohms_low) : 64'(ohms_high);
    // A zero resistance reads as one ohm
    if (den == 64'd0) den = 64'd1;
    if (r.chan == CH_LOW_X10 || r.chan == CH_HIGH_X10) den = den * X10_GAIN;
    num  = 64'(mag) * 64'(out_scale);
    quot = num / den;
    r.sat = 1'b0;
    if (!code[SAMPLE_BITS-1]) begin
      if (quot > 64'h7FFF_FFFF) begin
        quot  = 64'h7FFF_FFFF;
        r.sat = 1'b1;
      end
      r.current_value = quot[31:0];
    end else begin
      if (quot > 64'h8000_0000) begin
        quot  = 64'h8000_0000;
        r.sat = 1'b1;
      end
      r.current_value = ~quot[31:0] + 32'd1;
    end
    return r;
  endfunction

  // Code near a threshold, with a fair share of rail values and noise
  function automatic logic signed [SAMPLE_BITS-1:0] near_code(logic [THR_W-1:0] thr);
    int v;
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      3: return -16'sd1;
      4, 5: return 16'($urandom);
      default: begin
        v = int'(thr) + int'($urandom_range(2)) - 1;
        if ($urandom_range(1)) v = -v;
        return 16'(v);
      end
    endcase
  endfunction

  // Register values carry junk above the register width on purpose
  function automatic logic [CFG_W-1:0] pick_threshold();
    case ($urandom_range(5))
      0: return {9'($urandom), 15'h0000};
      1: return {9'($urandom), 15'h7FFF};
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_ohms();
    case ($urandom_range(7))
      0: return 24'd0;
      1: return 24'd1;
      2: return 24'hFF_FFFF;
      3: return 24'($urandom_range(1000));
      default: return 24'($urandom_range(50, 1));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_scale();
    case ($urandom_range(5))
      0: return 24'd0;
      1: return 24'hFF_FFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  // Write one register and mirror it; hold the enable for exactly one edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_LOW_RANGE_THR:  thr_low_range  = data[THR_W-1:0];
      REG_LOW_GAIN_THR:   thr_low_gain   = data[THR_W-1:0];
      REG_HIGH_RANGE_THR: thr_high_range = data[THR_W-1:0];
      REG_CLAMP_LEVEL:    clamp_lvl      = data[THR_W-1:0];
      REG_LOW_OHMS:       ohms_low       = data[OHMS_W-1:0];
      REG_HIGH_OHMS:      ohms_high      = data[OHMS_W-1:0];
      REG_OUTPUT_SCALE:   out_scale      = data[SCALE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Load a full setting, then poke the spare index with junk
  task automatic program_regs(input logic [CFG_W-1:0] lr, lg, hr, cl, lo, ho, sc);
    write_reg(REG_LOW_RANGE_THR, lr);
    write_reg(REG_LOW_GAIN_THR, lg);
    write_reg(REG_HIGH_RANGE_THR, hr);
    write_reg(REG_CLAMP_LEVEL, cl);
    write_reg(REG_LOW_OHMS, lo);
    write_reg(REG_HIGH_OHMS, ho);
    write_reg(REG_OUTPUT_SCALE, sc);
    write_reg(REG_SPARE, 24'($urandom));
  endtask

  task automatic add_scan(input logic signed [SAMPLE_BITS-1:0] a, b, c, d);
    scan_queue.push_back('{lx1: a, lx10: b, hx1: c, hx10: d});
    scans_in_flight++;
  endtask

  task automatic add_random_scans(input int count);
    logic [THR_W-1:0] hx1_ref;
    for (int n = 0; n < count; n++) begin
      // Aim the high x1 code at either edge of its usable window
      hx1_ref = $urandom_range(1) ? thr_high_range : clamp_lvl;
      add_scan(near_code(thr_low_range), near_code(thr_low_gain), near_code(hx1_ref),
               16'($urandom));
    end
  endtask

  // Every request returns one reading, so the block is idle once all are back
  task automatic wait_idle();
    while (scans_in_flight != 0) @(posedge clk);
  endtask

  // Request driver: offer queued scans, idle at random, hold while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        reading_queue.push_back(predict_reading(cur_scan));
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (scan_queue.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          cur_scan               = scan_queue.pop_front();
          in_bus.valid           <= 1'b1;
          in_bus.low_x1_sample   <= cur_scan.lx1;
          in_bus.low_x10_sample  <= cur_scan.lx10;
          in_bus.high_x1_sample  <= cur_scan.hx1;
          in_bus.high_x10_sample <= cur_scan.hx10;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Reading monitor: stall at random, check each accepted reading in order
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (reading_queue.size() == 0) begin
          errors++;
          $display("%0t: reading with no request pending: value %0d channel %0d sat %0b",
                   $time, out_bus.current_value, out_bus.source_channel, out_bus.saturated);
        end else begin
          want = reading_queue.pop_front();
          scans_in_flight--;
          if (out_bus.current_value !== want.current_value) begin
            errors++;
            $display("%0t: current_value expected %0d actual %0d",
                     $time, want.current_value, out_bus.current_value);
          end
          if (out_bus.source_channel !== want.chan) begin
            errors++;
            $display("%0t: source_channel expected %0d actual %0d",
                     $time, want.chan, out_bus.source_channel);
          end
          if (out_bus.saturated !== want.sat) begin
            errors++;
            $display("%0t: saturated expected %0b actual %0b",
                     $time, want.sat, out_bus.saturated);
          end
        end
      end
      out_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Count edges without any handshake; advance only while traffic is stuck
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin
    // Drive every input to a known value before the first edge
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_idx                = '0;
    cfg_wdata              = '0;
    in_bus.valid           = 1'b0;
    in_bus.low_x1_sample   = '0;
    in_bus.low_x10_sample  = '0;
    in_bus.high_x1_sample  = '0;
    in_bus.high_x10_sample = '0;
    out_bus.ready          = 1'b0;
    thr_low_range  = '0;
    thr_low_gain   = '0;
    thr_high_range = '0;
    clamp_lvl      = 15'h7FFF;
    ohms_low       = 24'd1;
    ohms_high      = 24'd1;
    out_scale      = 16'd1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset setting: thresholds at zero keep low x1 and pass codes through
    add_scan(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    add_scan(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    add_scan(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    add_scan(-16'sd1, 16'sd1, -16'sd1, 16'sd1);
    wait_idle();

    // Hand-picked setting; zero low-path ohms reads as one ohm
    program_regs(24'd20000, 24'd3000, 24'd500, 24'd30000, 24'd0, 24'd7, 24'd1000);
    add_scan(16'sd20000, 16'sd0, 16'sd0, 16'sd0);        // low x1 right at threshold
    add_scan(-16'sd20000, 16'sd0, 16'sd0, 16'sd0);
    add_scan(16'sh8000, 16'sd5, 16'sd5, 16'sd5);         // full-scale negative on low x1
    add_scan(16'sd19999, 16'sd3001, 16'sd0, 16'sd0);     // drop to low x10
    add_scan(-16'sd19999, -16'sd3001, 16'sd0, 16'sd0);
    add_scan(16'sd100, 16'sh8000, 16'sd0, 16'sd0);       // full-scale negative on low x10
    add_scan(16'sd100, 16'sd3000, 16'sd501, 16'sd9);     // low x10 not above: high x1
    add_scan(16'sd100, 16'sd3000, 16'sd500, 16'sd9);     // high x1 at floor: high x10
    add_scan(16'sd100, -16'sd3000, 16'sd29999, -16'sd9); // just under the clamp
    add_scan(16'sd100, 16'sd0, -16'sd29999, 16'sd9);
    add_scan(16'sd100, 16'sd0, 16'sd30000, 16'sd9);      // at clamp: high x10
    add_scan(16'sd100, 16'sd0, 16'sh8000, 16'sh8000);    // full-scale negative on both high
    add_scan(16'sd100, 16'sd0, 16'sh7FFF, 16'sh7FFF);
    add_scan(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    wait_idle();

    // Widest gain path: no thresholds, unit ohms, full scale
    program_regs(24'd0, 24'd0, 24'd0, 24'h7FFF, 24'd1, 24'd1, 24'hFFFF);
    add_random_scans(100);
    wait_idle();

    // All bits set, junk above the threshold and scale register widths; run without idling
    program_regs(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF,
                 24'hFF_FFFF, 24'hFF_FFFF);
    calm = 1'b1;
    add_random_scans(100);
    wait_idle();
    calm = 1'b0;

    // Random settings
    for (int phase = 0; phase < 5; phase++) begin
      program_regs(pick_threshold(), pick_threshold(), pick_threshold(), pick_threshold(),
                   pick_ohms(), pick_ohms(), pick_scale());
      if (phase == 2) begin
        // Starve the block until every reading is back, then resume
        add_random_scans(55);
        wait_idle();
        add_random_scans(55);
      end else begin
        add_random_scans(110);
      end
      wait_idle();
    end

    repeat (PIPE_LATENCY + 5) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== autorange_channel_stitcher.f =====
src/acs_pkg.sv
src/acs_intf.sv
src/acs_lane.sv
src/acs_merge.sv
src/acs_div_step.sv
src/autorange_channel_stitcher.sv
src/acs_checker.sv
sim/autorange_channel_stitcher_tb.sv
